// ===== hw/rtl/pscrc_pkg.sv =====
// shared types, constants and crc functions for the pcm sample crc-32 engine
// used by pscrc_chan, pscrc_report and the top level, depends on nothing

package pscrc_pkg;

   localparam int MAX_CHANNELS     = 10;
   localparam int MAX_SAMPLE_BYTES = 4;
   localparam int SELECT_W         = 10;
   localparam int SAMPLE_W         = 32;
   localparam int CRC_W            = 32;
   localparam int COUNT_W          = 32;
   localparam int SAMPLE_BYTES     = SAMPLE_W / 8;
   localparam int USED_BYTES       = (MAX_SAMPLE_BYTES < SAMPLE_BYTES) ?
                                     MAX_SAMPLE_BYTES : SAMPLE_BYTES;
   localparam int REP_CH           = (MAX_CHANNELS < SELECT_W) ? MAX_CHANNELS : SELECT_W;
   localparam int CH_AW            = $clog2(MAX_CHANNELS);
   localparam int CH_EXT           = 2 ** CH_AW;
   localparam int SLOT_W           = (CH_AW < 2) ? 2 : CH_AW;
   localparam int REPORT_SLOTS     = 3;
   localparam int POS_W            = 4;
   localparam int MAX_FRAME        = 2 ** POS_W;
   localparam int NCH_W            = POS_W + 1;
   localparam int NB_W             = 3;
   localparam int KIND_W           = 2;
   localparam int CHAN_W           = 4;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 10;
   localparam int RSP_DATA_W       = CRC_W + COUNT_W;
   localparam int RSP_USER_W       = KIND_W + CHAN_W;

   localparam logic [CRC_W-1:0] CRC_POLY_NORMAL = 32'h04C11DB7;
   localparam logic [CRC_W-1:0] CRC_PRESET      = 32'hFFFFFFFF;

   function automatic logic [CRC_W-1:0] reflect32(input logic [CRC_W-1:0] x);
      logic [CRC_W-1:0] r;
      for (int i = 0; i < CRC_W; i++) begin
         r[i] = x[CRC_W-1-i];
      end
      return r;
   endfunction

   localparam logic [CRC_W-1:0] CRC_POLY_REFL = reflect32(CRC_POLY_NORMAL);

   typedef enum logic [1:0] {
      MODE_WHOLE   = 2'd0,
      MODE_CHANNEL = 2'd1,
      MODE_REPORT  = 2'd2
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALL     = 2'd0,
      KIND_NONNULL = 2'd1,
      KIND_LEFT    = 2'd2,
      KIND_CHANNEL = 2'd3
   } kind_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SUM_MODE       = 3'd0,
      REG_SKIP_NULL      = 3'd1,
      REG_CHANNEL_SELECT = 3'd2,
      REG_FRAME_LEN      = 3'd3,
      REG_BYTES_PER_SAMP = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [1:0]          sum_mode;
      logic                skip_null;
      logic [SELECT_W-1:0] channel_select;
      logic [NCH_W-1:0]    frame_len;
      logic [NB_W-1:0]     bytes_per_sample;
   } cfg_type;

   typedef struct packed {
      logic [CRC_W-1:0]   sum_all;
      logic [CRC_W-1:0]   sum_nonnull;
      logic [CRC_W-1:0]   sum_left;
      logic [COUNT_W-1:0] byte_total;
   } sums_type;

   typedef struct packed {
      logic             en;
      logic [CH_AW-1:0] addr;
   } rd_req_type;

   function automatic mode_type norm_mode(input logic [1:0] m);
      case (m)
         MODE_CHANNEL: return MODE_CHANNEL;
         MODE_REPORT:  return MODE_REPORT;
         default:      return MODE_WHOLE;
      endcase
   endfunction

   function automatic logic [NCH_W-1:0] eff_channels(input logic [NCH_W-1:0] n);
      if (n == '0) begin
         return NCH_W'(1);
      end else if (n > NCH_W'(MAX_FRAME)) begin
         return NCH_W'(MAX_FRAME);
      end
      return n;
   endfunction

   function automatic logic [NB_W-1:0] eff_bytes(input logic [NB_W-1:0] n);
      if (n == '0) begin
         return NB_W'(1);
      end else if (n > NB_W'(USED_BYTES)) begin
         return NB_W'(USED_BYTES);
      end
      return n;
   endfunction

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ CRC_W'(b);
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [CRC_W-1:0] crc_sample(input logic [CRC_W-1:0] crc,
                                                   input logic [SAMPLE_W-1:0] value,
                                                   input logic [NB_W-1:0] nb);
      logic [CRC_W-1:0] c;
      c = crc;
      for (int k = 0; k < SAMPLE_BYTES; k++) begin
         if (NB_W'(k) < nb) begin
            c = crc_byte(c, value[8*k +: 8]);
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/pscrc_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies

module pscrc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pscrc_chan.sv =====
// sample path: frame position, two-stage read-modify-write of the per-channel
// sum ram with forwarding, scalar sums and byte count; uses pscrc_pkg, pscrc_ram

module pscrc_chan (
   input  logic                                clock,
   input  logic                                reset,
   input  pscrc_pkg::cfg_type                  cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_op,
   input  logic [pscrc_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                                rep_busy,
   input  pscrc_pkg::rd_req_type               rep_rd,
   input  logic                                clear,
   output logic                                fin_start,
   output pscrc_pkg::sums_type                 sums,
   output logic [pscrc_pkg::CRC_W-1:0]         mem_data
);

   logic                                 accept;
   logic [pscrc_pkg::NCH_W-1:0]          nch;
   logic [pscrc_pkg::NB_W-1:0]           nb;
   pscrc_pkg::mode_type                  mode;
   logic                                 nonnull;
   logic                                 keep;
   logic                                 reported;
   logic [pscrc_pkg::MAX_FRAME-1:0]      sel_ext;
   logic [pscrc_pkg::NCH_W-1:0]          pos_inc;
   logic                                 wr_ch0;
   logic                                 all0;
   logic                                 nn0;
   logic                                 left0;
   logic [pscrc_pkg::CH_AW-1:0]          addr0;

   logic [pscrc_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic                                 s1_valid_ff, s1_valid_in;
   logic                                 s1_fin_ff, s1_fin_in;
   logic                                 s1_wr_ch_ff, s1_wr_ch_in;
   logic                                 s1_all_ff, s1_all_in;
   logic                                 s1_nn_ff, s1_nn_in;
   logic                                 s1_left_ff, s1_left_in;
   logic [pscrc_pkg::SAMPLE_W-1:0]       s1_value_ff, s1_value_in;
   logic [pscrc_pkg::NB_W-1:0]           s1_nb_ff, s1_nb_in;
   logic [pscrc_pkg::CH_AW-1:0]          s1_addr_ff, s1_addr_in;
   logic                                 fwd_hit_ff, fwd_hit_in;
   logic [pscrc_pkg::CRC_W-1:0]          fwd_data_ff, fwd_data_in;
   logic                                 rvalid_ff, rvalid_in;
   logic [pscrc_pkg::MAX_CHANNELS-1:0]   chvalid_ff, chvalid_in;
   logic [pscrc_pkg::CH_EXT-1:0]         chvalid_ext;
   logic [pscrc_pkg::CH_EXT-1:0]         chvalid_ext_in;
   pscrc_pkg::sums_type                  sums_ff, sums_in;

   logic [pscrc_pkg::CRC_W-1:0]          crc_in;
   logic [pscrc_pkg::CRC_W-1:0]          ch_new;
   logic                                 ram_wr_en;
   logic                                 ram_rd_en;
   logic [pscrc_pkg::CH_AW-1:0]          ram_rd_addr;
   logic [pscrc_pkg::CRC_W-1:0]          ram_rd_data;

   assign fin_start  = s1_valid_ff && s1_fin_ff;
   assign req_tready = !fin_start && !rep_busy;
   assign accept     = req_tvalid && req_tready;

   // entry decode
   always_comb begin
      nch     = pscrc_pkg::eff_channels(cfg.frame_len);
      nb      = pscrc_pkg::eff_bytes(cfg.bytes_per_sample);
      mode    = pscrc_pkg::norm_mode(cfg.sum_mode);
      nonnull = 1'b0;
      for (int k = 0; k < pscrc_pkg::SAMPLE_BYTES; k++) begin
         if (pscrc_pkg::NB_W'(k) < nb && req_sample[8*k +: 8] != '0) begin
            nonnull = 1'b1;
         end
      end
      keep     = nonnull || !cfg.skip_null;
      sel_ext  = pscrc_pkg::MAX_FRAME'(cfg.channel_select);
      reported = ({1'b0, pos_ff} < nch) &&
                 (pos_ff < pscrc_pkg::POS_W'(pscrc_pkg::REP_CH)) &&
                 (nch < pscrc_pkg::NCH_W'(pscrc_pkg::MAX_CHANNELS)) &&
                 sel_ext[pos_ff];
      wr_ch0 = 1'b0;
      all0   = 1'b0;
      nn0    = 1'b0;
      left0  = 1'b0;
      case (mode)
         pscrc_pkg::MODE_CHANNEL: begin
            wr_ch0 = reported && keep;
         end
         pscrc_pkg::MODE_REPORT: begin
            all0  = 1'b1;
            nn0   = nonnull;
            left0 = nonnull && (pos_ff == '0);
         end
         default: begin
            all0 = keep;
         end
      endcase
      addr0   = wr_ch0 ? pscrc_pkg::CH_AW'(pos_ff) : '0;
      pos_inc = {1'b0, pos_ff} + 1'b1;
      pos_in  = pos_ff;
      if (accept) begin
         if (req_op == pscrc_pkg::OP_FINISH) begin
            pos_in = '0;
         end else begin
            pos_in = (pos_inc >= nch) ? '0 : pos_inc[pscrc_pkg::POS_W-1:0];
         end
      end
   end

   // update stage
   always_comb begin
      crc_in    = fwd_hit_ff ? fwd_data_ff : mem_data;
      ch_new    = pscrc_pkg::crc_sample(crc_in, s1_value_ff, s1_nb_ff);
      ram_wr_en = s1_valid_ff && s1_wr_ch_ff;

      s1_valid_in = accept;
      s1_fin_in   = accept && (req_op == pscrc_pkg::OP_FINISH);
      s1_wr_ch_in = accept && (req_op == pscrc_pkg::OP_SAMPLE) && wr_ch0;
      s1_all_in   = accept && (req_op == pscrc_pkg::OP_SAMPLE) && all0;
      s1_nn_in    = accept && (req_op == pscrc_pkg::OP_SAMPLE) && nn0;
      s1_left_in  = accept && (req_op == pscrc_pkg::OP_SAMPLE) && left0;
      s1_value_in = req_sample;
      s1_nb_in    = nb;
      s1_addr_in  = addr0;

      fwd_hit_in  = fwd_hit_ff;
      fwd_data_in = fwd_data_ff;
      if (accept) begin
         fwd_hit_in  = ram_wr_en && (s1_addr_ff == addr0);
         fwd_data_in = ch_new;
      end

      ram_rd_en   = accept || rep_rd.en;
      ram_rd_addr = rep_rd.en ? rep_rd.addr : addr0;
      chvalid_ext = pscrc_pkg::CH_EXT'(chvalid_ff);
      rvalid_in   = ram_rd_en ? chvalid_ext[ram_rd_addr] : rvalid_ff;

      chvalid_ext_in = chvalid_ext;
      if (ram_wr_en) begin
         chvalid_ext_in[s1_addr_ff] = 1'b1;
      end
      chvalid_in = clear ? '0 : chvalid_ext_in[pscrc_pkg::MAX_CHANNELS-1:0];

      sums_in = sums_ff;
      if (s1_valid_ff && !s1_fin_ff) begin
         if (s1_all_ff) begin
            sums_in.sum_all = pscrc_pkg::crc_sample(sums_ff.sum_all, s1_value_ff, s1_nb_ff);
         end
         if (s1_nn_ff) begin
            sums_in.sum_nonnull = pscrc_pkg::crc_sample(sums_ff.sum_nonnull, s1_value_ff,
                                                        s1_nb_ff);
         end
         if (s1_left_ff) begin
            sums_in.sum_left = pscrc_pkg::crc_sample(sums_ff.sum_left, s1_value_ff, s1_nb_ff);
         end
         sums_in.byte_total = sums_ff.byte_total + pscrc_pkg::COUNT_W'(s1_nb_ff);
      end
      if (clear) begin
         sums_in.sum_all     = pscrc_pkg::CRC_PRESET;
         sums_in.sum_nonnull = pscrc_pkg::CRC_PRESET;
         sums_in.sum_left    = pscrc_pkg::CRC_PRESET;
         sums_in.byte_total  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s1_fin_ff   <= 1'b0;
         s1_wr_ch_ff <= 1'b0;
         s1_all_ff   <= 1'b0;
         s1_nn_ff    <= 1'b0;
         s1_left_ff  <= 1'b0;
         fwd_hit_ff  <= 1'b0;
         rvalid_ff   <= 1'b0;
         chvalid_ff  <= '0;
         sums_ff.sum_all     <= pscrc_pkg::CRC_PRESET;
         sums_ff.sum_nonnull <= pscrc_pkg::CRC_PRESET;
         sums_ff.sum_left    <= pscrc_pkg::CRC_PRESET;
         sums_ff.byte_total  <= '0;
      end else begin
         pos_ff      <= pos_in;
         s1_valid_ff <= s1_valid_in;
         s1_fin_ff   <= s1_fin_in;
         s1_wr_ch_ff <= s1_wr_ch_in;
         s1_all_ff   <= s1_all_in;
         s1_nn_ff    <= s1_nn_in;
         s1_left_ff  <= s1_left_in;
         fwd_hit_ff  <= fwd_hit_in;
         rvalid_ff   <= rvalid_in;
         chvalid_ff  <= chvalid_in;
         sums_ff     <= sums_in;
      end
      s1_value_ff <= s1_value_in;
      s1_nb_ff    <= s1_nb_in;
      s1_addr_ff  <= s1_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

   pscrc_ram #(
      .WIDTH (pscrc_pkg::CRC_W),
      .DEPTH (pscrc_pkg::MAX_CHANNELS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (ch_new),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // entries not written since the last clear read as the preset
   assign mem_data = rvalid_ff ? ram_rd_data : pscrc_pkg::CRC_PRESET;
   assign sums     = sums_ff;

endmodule

// ===== hw/rtl/pscrc_report.sv =====
// finish sequencer: walks the sums to report, reads channel sums from the ram,
// fills the result register and clears the state; uses pscrc_pkg

module pscrc_report (
   input  logic                                clock,
   input  logic                                reset,
   input  pscrc_pkg::cfg_type                  cfg,
   input  logic                                start,
   input  pscrc_pkg::sums_type                 sums,
   input  logic [pscrc_pkg::CRC_W-1:0]         mem_data,
   output pscrc_pkg::rd_req_type               rd_req,
   output logic                                clear,
   output logic                                busy,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pscrc_pkg::CRC_W-1:0]         rsp_crc,
   output logic [pscrc_pkg::KIND_W-1:0]        rsp_kind,
   output logic [pscrc_pkg::CHAN_W-1:0]        rsp_chan,
   output logic [pscrc_pkg::COUNT_W-1:0]       rsp_bytes,
   output logic                                rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                         found;
      logic [pscrc_pkg::SLOT_W-1:0] idx;
   } hit_type;

   function automatic hit_type first_from(input logic [pscrc_pkg::REP_CH-1:0] mask,
                                          input logic [pscrc_pkg::SLOT_W:0] from);
      hit_type h;
      h = '0;
      for (int i = pscrc_pkg::REP_CH - 1; i >= 0; i--) begin
         if (mask[i] && ((pscrc_pkg::SLOT_W + 1)'(i) >= from)) begin
            h.found = 1'b1;
            h.idx   = pscrc_pkg::SLOT_W'(i);
         end
      end
      return h;
   endfunction

   state_type                          state_ff, state_in;
   logic [pscrc_pkg::SLOT_W-1:0]       cursor_ff, cursor_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [pscrc_pkg::CRC_W-1:0]        rsp_crc_ff, rsp_crc_in;
   logic [pscrc_pkg::KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [pscrc_pkg::CHAN_W-1:0]       rsp_chan_ff, rsp_chan_in;
   logic [pscrc_pkg::COUNT_W-1:0]      rsp_bytes_ff, rsp_bytes_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [pscrc_pkg::NCH_W-1:0]        nch;
   pscrc_pkg::mode_type                mode;
   logic [pscrc_pkg::REP_CH-1:0]       rep;
   hit_type                            hit_first;
   hit_type                            hit_next;
   logic                               load;
   logic                               done;
   logic [pscrc_pkg::CRC_W-1:0]        sum_sel;
   pscrc_pkg::kind_type                kind_sel;

   always_comb begin
      nch  = pscrc_pkg::eff_channels(cfg.frame_len);
      mode = pscrc_pkg::norm_mode(cfg.sum_mode);
      for (int i = 0; i < pscrc_pkg::REP_CH; i++) begin
         rep[i] = (pscrc_pkg::NCH_W'(i) < nch) &&
                  (nch < pscrc_pkg::NCH_W'(pscrc_pkg::MAX_CHANNELS)) &&
                  cfg.channel_select[i];
      end
      hit_first = first_from(rep, '0);
      hit_next  = first_from(rep, {1'b0, cursor_ff} + 1'b1);
      load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

      state_in     = state_ff;
      cursor_in    = cursor_ff;
      clear        = 1'b0;
      done         = 1'b0;
      rd_req.en    = 1'b0;
      rd_req.addr  = pscrc_pkg::CH_AW'(cursor_ff);
      sum_sel      = sums.sum_all;
      kind_sel     = pscrc_pkg::KIND_ALL;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_crc_in   = rsp_crc_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (mode == pscrc_pkg::MODE_CHANNEL) begin
                  if (hit_first.found) begin
                     cursor_in = hit_first.idx;
                     state_in  = ST_READ;
                  end else begin
                     clear = 1'b1;
                  end
               end else begin
                  cursor_in = '0;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_req.en = (mode == pscrc_pkg::MODE_CHANNEL);
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (load) begin
               case (mode)
                  pscrc_pkg::MODE_CHANNEL: begin
                     sum_sel  = mem_data;
                     kind_sel = pscrc_pkg::KIND_CHANNEL;
                     if (hit_next.found) begin
                        cursor_in = hit_next.idx;
                     end else begin
                        done = 1'b1;
                     end
                  end
                  pscrc_pkg::MODE_REPORT: begin
                     case (cursor_ff)
                        pscrc_pkg::SLOT_W'(pscrc_pkg::KIND_ALL): begin
                           sum_sel  = sums.sum_all;
                           kind_sel = pscrc_pkg::KIND_ALL;
                        end
                        pscrc_pkg::SLOT_W'(pscrc_pkg::KIND_NONNULL): begin
                           sum_sel  = sums.sum_nonnull;
                           kind_sel = pscrc_pkg::KIND_NONNULL;
                        end
                        default: begin
                           sum_sel  = sums.sum_left;
                           kind_sel = pscrc_pkg::KIND_LEFT;
                        end
                     endcase
                     if (cursor_ff >= pscrc_pkg::SLOT_W'(pscrc_pkg::REPORT_SLOTS - 1)) begin
                        done = 1'b1;
                     end else begin
                        cursor_in = cursor_ff + 1'b1;
                     end
                  end
                  default: begin
                     sum_sel  = sums.sum_all;
                     kind_sel = cfg.skip_null ? pscrc_pkg::KIND_NONNULL : pscrc_pkg::KIND_ALL;
                     done     = 1'b1;
                  end
               endcase
               rsp_valid_in = 1'b1;
               rsp_crc_in   = sum_sel ^ pscrc_pkg::CRC_PRESET;
               rsp_kind_in  = kind_sel;
               rsp_chan_in  = (mode == pscrc_pkg::MODE_CHANNEL) ?
                              pscrc_pkg::CHAN_W'(cursor_ff) : '0;
               rsp_bytes_in = sums.byte_total;
               rsp_last_in  = done;
               clear        = done;
               state_in     = done ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_crc_ff   <= rsp_crc_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_crc    = rsp_crc_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_chan   = rsp_chan_ff;
   assign rsp_bytes  = rsp_bytes_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== hw/rtl/pcm_sample_crc32_engine.sv =====
// samples: one item a cycle while no finish is in progress; each is folded into
// its sums in the cycle after acceptance. finish: each result takes a ram read,
// then a load into the output register, held by rsp_tready; input reopens the cycle
// after the last load, or after the update stage when there is nothing to report
// reset: synchronous; sums read as all ones through per-entry valid bits, no sweep
// uses pscrc_pkg, pscrc_chan, pscrc_report

module pcm_sample_crc32_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [pscrc_pkg::SAMPLE_W-1:0]        req_tdata,   // sample_value
   input  logic [0:0]                            req_tuser,   // op
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [pscrc_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // crc_value, bytes_used
   output logic [pscrc_pkg::RSP_USER_W-1:0]      rsp_tuser,   // sum_kind, channel_number
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pscrc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pscrc_pkg::CSR_DATA_W-1:0]      csr_data
);

   pscrc_pkg::cfg_type                 cfg_ff, cfg_in;
   pscrc_pkg::sums_type                sums;
   pscrc_pkg::rd_req_type              rep_rd;
   logic [pscrc_pkg::CRC_W-1:0]        mem_data;
   logic                               clear;
   logic                               busy;
   logic                               fin_start;
   logic [pscrc_pkg::CRC_W-1:0]        rsp_crc;
   logic [pscrc_pkg::KIND_W-1:0]       rsp_kind;
   logic [pscrc_pkg::CHAN_W-1:0]       rsp_chan;
   logic [pscrc_pkg::COUNT_W-1:0]      rsp_bytes;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pscrc_pkg::REG_SUM_MODE:       cfg_in.sum_mode         = csr_data[1:0];
            pscrc_pkg::REG_SKIP_NULL:      cfg_in.skip_null        = csr_data[0];
            pscrc_pkg::REG_CHANNEL_SELECT: cfg_in.channel_select   = csr_data;
            pscrc_pkg::REG_FRAME_LEN:      cfg_in.frame_len        =
                                              csr_data[pscrc_pkg::NCH_W-1:0];
            pscrc_pkg::REG_BYTES_PER_SAMP: cfg_in.bytes_per_sample =
                                              csr_data[pscrc_pkg::NB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sum_mode         <= pscrc_pkg::MODE_WHOLE;
         cfg_ff.skip_null        <= 1'b0;
         cfg_ff.channel_select   <= '0;
         cfg_ff.frame_len        <= pscrc_pkg::NCH_W'(2);
         cfg_ff.bytes_per_sample <= pscrc_pkg::NB_W'(2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pscrc_chan u_chan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[0]),
      .req_sample (req_tdata),
      .rep_busy   (busy),
      .rep_rd     (rep_rd),
      .clear      (clear),
      .fin_start  (fin_start),
      .sums       (sums),
      .mem_data   (mem_data)
   );

   pscrc_report u_report (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .start      (fin_start),
      .sums       (sums),
      .mem_data   (mem_data),
      .rd_req     (rep_rd),
      .clear      (clear),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_crc    (rsp_crc),
      .rsp_kind   (rsp_kind),
      .rsp_chan   (rsp_chan),
      .rsp_bytes  (rsp_bytes),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {rsp_bytes, rsp_crc};
   assign rsp_tuser = {rsp_chan, rsp_kind};

endmodule
